@@ rtl/crc8fr_pkg.sv @@
// Shared constants, codes and the CRC-8 step for the CRC-8 frame receiver.
// No dependencies; the receiver and the testbench import this package.
package crc8fr_pkg;

    // Frame buffer size and number of entries in the length table.
    localparam int BUF_BYTES  = 32;
    localparam int TYPE_SLOTS = 8;
    localparam int IDX_W      = $clog2(BUF_BYTES);

    // Register widths.
    localparam int TC_W    = 4;
    localparam int TBL_W   = 40;
    localparam int GAP_W   = 16;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 2;
    localparam int ENT_W   = 5;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0] CRC_POLY = 8'h07;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TABLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT    = 2'd2;

    // Request function codes.
    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_TICK    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_BUSY    = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_ERROR   = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_DROPPED = 3'd4;

    // One byte of CRC-8, MSB first, eight shifts.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ rtl/crc8fr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the frame buffer.
module crc8fr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/crc8_frame_receiver.sv @@
// Receives length-prefixed frames protected by CRC-8 and hands out accepted payloads.
// Depends on crc8fr_pkg and crc8fr_ram (frame buffer).
//
// Each request is a received byte, a timer tick or a release. A frame is a length
// byte L, a type byte, L payload bytes and a CRC-8 (polynomial 0x07, initial value
// zero) over all bytes before it; it ends at byte L+2 or at the last buffer entry.
// A good frame gives one result per payload byte in the buffer (status good, tlast
// on the final one), or a single good result if it has none; the receiver then
// drops bytes until a release request. Every other request gives exactly one
// result. The block works on one request at a time and takes a new one only once
// the last result is taken. Each payload byte of a good frame passes through S_RD,
// S_WAIT and S_OUT (address, registered buffer read, output register).
module crc8_frame_receiver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [crc8fr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crc8fr_pkg::CFG_W-1:0]         i_cfg_wdata,
    // Request stream.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: func [1:0], rx_byte [9:2], zero [15:10]
    input  logic [crc8fr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Result stream.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: status [2:0], packet_type [10:3], payload_byte [18:11], zero [23:19]
    output logic [crc8fr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                                 o_m_axis_tlast
);

    import crc8fr_pkg::*;

    // Controller state codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OUT  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [TC_W-1:0]  r_type_count;
    logic [TBL_W-1:0] r_length_table;
    logic [GAP_W-1:0] r_gap_limit;

    logic [IDX_W-1:0] r_byte_index, n_byte_index;
    logic [7:0]       r_crc, n_crc;
    logic [GAP_W-1:0] r_idle_ticks, n_idle_ticks;
    logic             r_armed, n_armed;
    logic             r_holding, n_holding;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_type, n_type;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    logic             r_out_valid, n_out_valid;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_pkt_type, n_pkt_type;
    logic [7:0]       r_payload, n_payload;
    logic             r_last, n_last;

    logic             in_accept;
    logic [1:0]       in_func;
    logic [7:0]       in_byte;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    // Decode of the byte request.
    logic [7:0]       cur_len;
    logic             frame_end;
    logic [TC_W-1:0]  type_limit;
    logic [ENT_W-1:0] table_len;
    logic             frame_ok;
    logic [IDX_W-1:0] body_len;
    logic [IDX_W-1:0] emit_n;
    logic [GAP_W-1:0] tick_limit;
    logic [GAP_W-1:0] ticks_inc;

    assign in_func   = i_s_axis_tdata[1:0];
    assign in_byte   = i_s_axis_tdata[9:2];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign ram_we    = in_accept && (in_func == FUNC_BYTE) && !r_holding;

    // Frame buffer: written with each byte, read back while the payload is sent.
    crc8fr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_byte_index),
        .i_wdata (in_byte),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Frame end detection and acceptance checks.
    always_comb begin
        cur_len    = (r_byte_index == '0) ? in_byte : r_len;
        frame_end  = (({1'b0, cur_len} + 9'd2) == 9'(r_byte_index))
                     || (r_byte_index == IDX_W'(BUF_BYTES - 1));
        type_limit = (r_type_count > TC_W'(TYPE_SLOTS)) ? TC_W'(TYPE_SLOTS) : r_type_count;
        table_len  = r_length_table[ENT_W * int'(r_type[2:0]) +: ENT_W];
        frame_ok   = (r_crc == in_byte) && (r_type < {4'd0, type_limit})
                     && (cur_len == {3'd0, table_len});
        body_len   = r_byte_index - IDX_W'(2);
        emit_n     = ({1'b0, cur_len} < 9'(body_len)) ? cur_len[IDX_W-1:0] : body_len;
        tick_limit = (r_gap_limit == '0) ? GAP_W'(1) : r_gap_limit;
        ticks_inc  = (r_idle_ticks != '1) ? r_idle_ticks + GAP_W'(1) : r_idle_ticks;
    end

    // Request handling and payload walk.
    always_comb begin
        n_state      = r_state;
        n_byte_index = r_byte_index;
        n_crc        = r_crc;
        n_idle_ticks = r_idle_ticks;
        n_armed      = r_armed;
        n_holding    = r_holding;
        n_len        = r_len;
        n_type       = r_type;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_pkt_type   = r_pkt_type;
        n_payload    = r_payload;
        n_last       = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state     = S_OUT;
                    n_out_valid = 1'b1;
                    n_status    = ST_BUSY;
                    n_pkt_type  = 8'd0;
                    n_payload   = 8'd0;
                    n_last      = 1'b1;
                    case (in_func)
                        FUNC_BYTE: begin
                            if (r_holding) begin
                                n_status = ST_DROPPED;
                            end else begin
                                n_armed      = 1'b0;
                                n_idle_ticks = '0;
                                if (r_byte_index == '0) begin
                                    n_len = in_byte;
                                end
                                if (r_byte_index == IDX_W'(1)) begin
                                    n_type = in_byte;
                                end
                                if (frame_end) begin
                                    if (!frame_ok) begin
                                        n_byte_index = '0;
                                        n_crc        = 8'd0;
                                        n_status     = ST_ERROR;
                                    end else begin
                                        n_holding = 1'b1;
                                        if (emit_n == '0) begin
                                            n_status   = ST_GOOD;
                                            n_pkt_type = r_type;
                                        end else begin
                                            // Walk the payload out of the buffer.
                                            n_out_valid = 1'b0;
                                            n_addr      = IDX_W'(2);
                                            n_cnt       = emit_n;
                                            n_state     = S_RD;
                                        end
                                    end
                                end else begin
                                    n_crc        = crc8_byte(r_crc, in_byte);
                                    n_byte_index = r_byte_index + IDX_W'(1);
                                    n_armed      = 1'b1;
                                end
                            end
                        end
                        FUNC_TICK: begin
                            if (r_armed && !r_holding) begin
                                if (ticks_inc >= tick_limit) begin
                                    n_byte_index = '0;
                                    n_crc        = 8'd0;
                                    n_armed      = 1'b0;
                                    n_idle_ticks = '0;
                                    n_status     = ST_TIMEOUT;
                                end else begin
                                    n_idle_ticks = ticks_inc;
                                end
                            end
                        end
                        FUNC_RELEASE: begin
                            if (r_holding) begin
                                n_holding    = 1'b0;
                                n_byte_index = '0;
                                n_crc        = 8'd0;
                                n_armed      = 1'b0;
                                n_idle_ticks = '0;
                            end
                        end
                        default: begin
                            n_status = ST_BUSY;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
                n_status    = ST_GOOD;
                n_pkt_type  = r_type;
                n_payload   = ram_rdata;
                n_last      = (r_cnt == IDX_W'(1));
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr + IDX_W'(1);
                        n_cnt   = r_cnt - IDX_W'(1);
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_type_count   <= '0;
            r_length_table <= '0;
            r_gap_limit    <= GAP_W'(1);
            r_byte_index   <= '0;
            r_crc          <= 8'd0;
            r_idle_ticks   <= '0;
            r_armed        <= 1'b0;
            r_holding      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_index <= n_byte_index;
            r_crc        <= n_crc;
            r_idle_ticks <= n_idle_ticks;
            r_armed      <= n_armed;
            r_holding    <= n_holding;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_TYPE_COUNT:   r_type_count   <= i_cfg_wdata[TC_W-1:0];
                    CFG_LENGTH_TABLE: r_length_table <= i_cfg_wdata[TBL_W-1:0];
                    CFG_GAP_LIMIT:    r_gap_limit    <= i_cfg_wdata[GAP_W-1:0];
                    default:          r_gap_limit    <= r_gap_limit;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_type     <= n_type;
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
        r_pkt_type <= n_pkt_type;
        r_payload  <= n_payload;
        r_last     <= n_last;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_payload, r_pkt_type, r_status};
    assign o_m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    // A result waiting at the output blocks new requests.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("request taken while a result is pending");

    // Holding ends only through reset or a release request.
    a_hold_release: assert property (@(posedge i_clk)
        $fell(r_holding) |-> (!$past(i_rst_n)
            || $past(in_accept && (in_func == FUNC_RELEASE))))
        else $error("holding cleared without a release");

    // Payload is read back only for an accepted frame.
    a_walk_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> r_holding)
        else $error("payload read while not holding");

    // Only payload bytes may come without tlast.
    a_notlast_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |-> (r_status == ST_GOOD))
        else $error("non-final result that is not a payload byte");
`endif

endmodule

@@ sim/crc8_frame_receiver_test.sv @@
// Self-checking testbench for crc8_frame_receiver: drives request streams of framed bytes,
// ticks and releases, predicts results in-bench or takes them from the directed table,
// and compares them field by field. Depends on crc8fr_pkg and the crc8_frame_receiver RTL only.
module crc8_frame_receiver_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crc8fr_pkg::*;

    // The spare function code, which the block must ignore.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // Rows of the directed table at which the registers are rewritten.
    localparam int CFG_A_ROW = 3;
    localparam int CFG_B_ROW = 20;
    localparam int DIR_ROWS  = 29;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] ptype;
        logic [7:0] pbyte;
        logic       last;
    } t_rx_result;

    // Where a directed byte comes from: the table itself, the running CRC, or the running CRC with bit 0 flipped.
    typedef enum logic [1:0] {SRC_LIT, SRC_CRC, SRC_BAD_CRC} t_byte_src;

    typedef struct packed {
        logic [1:0] func;
        t_byte_src  src;
        logic [7:0] data;
        logic       typed;
        logic [2:0] status;
        logic [7:0] ptype;
    } t_stim_row;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    // Receiver model state and its copy of the registers.
    logic [7:0]  rx_buf [BUF_BYTES];
    logic [4:0]  rx_pos = '0;
    logic [7:0]  rx_crc = '0;
    logic [15:0] gap_count = '0;
    bit          gap_armed = 1'b0;
    bit          held = 1'b0;
    logic [3:0]  m_types = '0;
    logic [39:0] m_lengths = '0;
    logic [15:0] m_gap = 16'd1;

    t_rx_result step_results [$];
    t_rx_result frame_results_due [$];

    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    logic rx_hold = 1'b0;
    int  requests_sent = 0;
    int  mismatches = 0;
    event hold_go;

    // Directed requests; typed rows carry a result that is plain from the frame rules.
    t_stim_row directed_rows [DIR_ROWS] = '{
        '{FUNC_RELEASE, SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_TICK,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_NONE,    SRC_LIT,     8'hFF, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_CRC,     8'h00, 1'b1, ST_GOOD,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'hFF, 1'b1, ST_DROPPED, 8'h00},
        '{FUNC_TICK,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_RELEASE, SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h01, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h01, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'hA5, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_CRC,     8'h00, 1'b0, ST_BUSY,    8'h00},
        '{FUNC_RELEASE, SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_BAD_CRC, 8'h00, 1'b1, ST_ERROR,   8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h05, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_TICK,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_TICK,    SRC_LIT,     8'h00, 1'b1, ST_TIMEOUT, 8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h80, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_TICK,    SRC_LIT,     8'h00, 1'b1, ST_TIMEOUT, 8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h07, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_CRC,     8'h00, 1'b1, ST_GOOD,    8'h07},
        '{FUNC_RELEASE, SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h00, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_LIT,     8'h08, 1'b1, ST_BUSY,    8'h00},
        '{FUNC_BYTE,    SRC_CRC,     8'h00, 1'b1, ST_ERROR,   8'h00}
    };

    crc8_frame_receiver u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always #4 clk = ~clk;

    // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) begin
            if (r[7]) begin
                r = (r << 1) ^ 8'h07;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    function automatic void clear_frame();
        rx_pos = '0;
        rx_crc = '0;
    endfunction

    // Works out the results of one request and advances the receiver state.
    function automatic void predict_request(input logic [1:0] f, input logic [7:0] b);
        logic [4:0] pos;
        logic [7:0] len;
        logic [7:0] ty;
        int         n;
        int         lim;
        bit         ok;
        step_results.delete();
        case (f)
            FUNC_BYTE: begin
                if (held) begin
                    step_results.push_back(t_rx_result'{ST_DROPPED, 8'h00, 8'h00, 1'b1});
                    return;
                end
                pos = rx_pos;
                rx_buf[pos] = b;
                gap_armed = 1'b0;
                gap_count = '0;
                len = rx_buf[0];
                if (int'(pos) == int'(len) + 2 || int'(pos) == BUF_BYTES - 1) begin
                    // The CRC byte closes the frame.
                    ty = rx_buf[1];
                    lim = (m_types > TYPE_SLOTS) ? TYPE_SLOTS : int'(m_types);
                    ok = (rx_crc == b) && (int'(ty) < lim)
                         && (len == {3'b000, m_lengths[5 * ty[2:0] +: 5]});
                    if (!ok) begin
                        clear_frame();
                        step_results.push_back(t_rx_result'{ST_ERROR, 8'h00, 8'h00, 1'b1});
                        return;
                    end
                    held = 1'b1;
                    n = int'(pos) - 2;
                    if (int'(len) < n) begin
                        n = int'(len);
                    end
                    if (n == 0) begin
                        step_results.push_back(t_rx_result'{ST_GOOD, ty, 8'h00, 1'b1});
                    end
                    for (int i = 0; i < n; i++) begin
                        step_results.push_back(t_rx_result'{ST_GOOD, ty, rx_buf[2 + i],
                                                            i == n - 1});
                    end
                    return;
                end
                rx_crc = crc8_step(rx_crc, b);
                rx_pos = pos + 5'd1;
                gap_armed = 1'b1;
            end
            FUNC_TICK: begin
                lim = (m_gap == 16'd0) ? 1 : int'(m_gap);
                if (gap_armed && !held) begin
                    if (gap_count != 16'hFFFF) begin
                        gap_count++;
                    end
                    if (int'(gap_count) >= lim) begin
                        clear_frame();
                        gap_armed = 1'b0;
                        gap_count = '0;
                        step_results.push_back(t_rx_result'{ST_TIMEOUT, 8'h00, 8'h00, 1'b1});
                        return;
                    end
                end
            end
            FUNC_RELEASE: begin
                if (held) begin
                    held = 1'b0;
                    clear_frame();
                    gap_armed = 1'b0;
                    gap_count = '0;
                end
            end
            default: begin
            end
        endcase
        step_results.push_back(t_rx_result'{ST_BUSY, 8'h00, 8'h00, 1'b1});
    endfunction

    // Offers one request, waits for it to be taken and records what it should give.
    task automatic send_request(input logic [1:0] f, input logic [7:0] b,
                                input bit typed = 1'b0, input t_rx_result typed_res = '0);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b000000, b, f};
        do @(posedge clk); while (!s_tready);
        predict_request(f, b);
        if (typed) begin
            frame_results_due.push_back(typed_res);
        end else begin
            foreach (step_results[k]) frame_results_due.push_back(step_results[k]);
        end
        if (f != FUNC_NONE) begin
            requests_sent++;
        end
    endtask

    // Stops offering requests and waits until every predicted result has arrived.
    task automatic finish_requests();
        s_tvalid <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge clk);
    endtask

    // Writes all three registers one after another; only called with the block idle.
    task automatic set_config(input logic [3:0] tc, input logic [39:0] tbl,
                              input logic [15:0] gap);
        cfg_we <= 1'b1;
        cfg_index <= CFG_TYPE_COUNT;
        cfg_wdata <= CFG_W'(tc);
        @(posedge clk);
        cfg_index <= CFG_LENGTH_TABLE;
        cfg_wdata <= tbl;
        @(posedge clk);
        cfg_index <= CFG_GAP_LIMIT;
        cfg_wdata <= CFG_W'(gap);
        @(posedge clk);
        cfg_we <= 1'b0;
        m_types = tc;
        m_lengths = tbl;
        m_gap = gap;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [39:0] rand_lengths(input int max_len);
        logic [39:0] t;
        for (int k = 0; k < TYPE_SLOTS; k++) begin
            t[5 * k +: 5] = 5'($urandom_range(max_len));
        end
        return t;
    endfunction

    // Feeds random bytes until the open frame closes on its own.
    task automatic close_open_frame();
        while (rx_pos != 0 && !held) send_request(FUNC_BYTE, rand_byte());
    endtask

    // One frame with the given header, now and then one to three harmless ticks between bytes.
    task automatic send_frame(input logic [7:0] len, input logic [7:0] ty, input bit crc_good);
        int crc_at;
        int gap_eff;
        crc_at = (int'(len) + 2 < BUF_BYTES) ? int'(len) + 2 : BUF_BYTES - 1;
        gap_eff = (m_gap == 16'd0) ? 1 : int'(m_gap);
        for (int k = 0; k < crc_at; k++) begin
            send_request(FUNC_BYTE, (k == 0) ? len : (k == 1) ? ty : rand_byte());
            if (gap_eff > 1 && $urandom_range(5) == 0) begin
                repeat ($urandom_range(1, (gap_eff > 4) ? 3 : gap_eff - 1))
                    send_request(FUNC_TICK, rand_byte());
            end
        end
        send_request(FUNC_BYTE, crc_good ? rx_crc : rx_crc ^ (8'h01 << $urandom_range(7)));
    endtask

    // Mostly well-formed frames, with broken frames, timeouts and stray requests mixed in.
    task automatic run_traffic(input int target);
        int pick;
        int lim;
        int gap_eff;
        logic [7:0] ty;
        requests_sent = 0;
        while (requests_sent < target) begin
            pick = $urandom_range(99);
            lim = (m_types > TYPE_SLOTS) ? TYPE_SLOTS : int'(m_types);
            gap_eff = (m_gap == 16'd0) ? 1 : int'(m_gap);
            ty = (lim > 0) ? 8'($urandom_range(lim - 1)) : 8'h00;
            if (held) begin
                // A packet is out: mostly release it, sometimes poke the held receiver.
                if (pick < 70) begin
                    send_request(FUNC_RELEASE, rand_byte());
                end else if (pick < 85) begin
                    send_request(FUNC_BYTE, rand_byte());
                end else begin
                    send_request(FUNC_TICK, rand_byte());
                end
            end else if (rx_pos != 0) begin
                close_open_frame();
            end else if (pick < 60 && lim > 0) begin
                send_frame({3'b000, m_lengths[5 * ty[2:0] +: 5]}, ty, 1'b1);
            end else if (pick < 72) begin
                send_frame(8'($urandom_range(31)), rand_byte(), 1'b1);
            end else if (pick < 82 && lim > 0) begin
                send_frame({3'b000, m_lengths[5 * ty[2:0] +: 5]}, ty, 1'b0);
            end else if (pick < 90) begin
                send_request(FUNC_BYTE, rand_byte());
                close_open_frame();
            end else if (pick < 96) begin
                // A frame cut short, left to time out where the limit is small.
                repeat ($urandom_range(1, 2)) send_request(FUNC_BYTE, 8'($urandom_range(31)));
                if (gap_eff <= 8) begin
                    while (rx_pos != 0) send_request(FUNC_TICK, rand_byte());
                end else begin
                    close_open_frame();
                end
            end else begin
                case ($urandom_range(2))
                    0: send_request(FUNC_TICK, rand_byte());
                    1: send_request(FUNC_RELEASE, rand_byte());
                    default: send_request(FUNC_NONE, rand_byte());
                endcase
            end
        end
    endtask

    task automatic run_phase(input logic [3:0] tc, input logic [39:0] tbl, input logic [15:0] gap,
                             input int tx_pct, input int rx_pct, input int target,
                             input bit squeeze);
        finish_requests();
        set_config(tc, tbl, gap);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze) begin
            -> hold_go;
        end
        run_traffic(target);
    endtask

    // Compares one accepted result with the oldest prediction.
    task automatic check_result();
        t_rx_result want;
        if (frame_results_due.size() == 0) begin
            $error("unexpected result: status %0d, payload_byte %0d", m_tdata[2:0],
                   m_tdata[18:11]);
            mismatches++;
            return;
        end
        want = frame_results_due.pop_front();
        if (m_tdata[2:0] != want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
            mismatches++;
        end
        if (m_tdata[10:3] != want.ptype) begin
            $error("packet_type: expected %0d, got %0d", want.ptype, m_tdata[10:3]);
            mismatches++;
        end
        if (m_tdata[18:11] != want.pbyte) begin
            $error("payload_byte: expected %0d, got %0d", want.pbyte, m_tdata[18:11]);
            mismatches++;
        end
        if (m_tlast != want.last) begin
            $error("last: expected %0d, got %0d", want.last, m_tlast);
            mismatches++;
        end
    endtask

    // Result side: check on every handshake, then pick the next ready level.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            check_result();
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end

    // Long receiver hold-off, so that the block backs up and stalls its request side.
    initial begin
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (400) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Watchdog.
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        t_stim_row  row;
        logic [7:0] b;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset values first, then two register settings.
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = directed_rows[i];
            if (i == CFG_A_ROW) begin
                finish_requests();
                set_config(4'd3, 40'h00_0000_0C20, 16'd2);
            end else if (i == CFG_B_ROW) begin
                // Type count above the table size, type 7 empty, gap limit zero.
                finish_requests();
                set_config(4'hF, 40'h07_FFFF_FFFF, 16'd0);
            end
            case (row.src)
                SRC_CRC: b = rx_crc;
                SRC_BAD_CRC: b = rx_crc ^ 8'h01;
                default: b = row.data;
            endcase
            send_request(row.func, b, row.typed,
                         t_rx_result'{row.status, row.ptype, 8'h00, 1'b1});
        end

        // Random part over several settings and handshake patterns.
        run_phase(4'd8, rand_lengths(6), 16'd3, 0, 0, 110, 1'b1);
        run_phase(4'd2, 40'hFF_FFFF_FFFF, 16'd1, 85, 0, 50, 1'b0);
        run_phase(4'd6, rand_lengths(9), 16'hFFFF, 0, 85, 100, 1'b0);
        run_phase(4'd5, rand_lengths(4), 16'd4, 34, 34, 70, 1'b0);
        run_phase(4'd0, 40'h00_0000_0000, 16'd2, 0, 0, 25, 1'b0);

        finish_requests();
        repeat (40) @(posedge clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/crc8fr_pkg.sv
rtl/crc8fr_ram.sv
rtl/crc8_frame_receiver.sv
sim/crc8_frame_receiver_test.sv
